FILE: rtl/rc_pulse_width_capture_core_defines.svh
// Assertion macros for the RC pulse-width capture core.
// Used by the top level only; no other dependencies.
`ifndef RC_PULSE_WIDTH_CAPTURE_CORE_DEFINES_SVH
`define RC_PULSE_WIDTH_CAPTURE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RPWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPWC_ASSERT(lbl, prop, msg)
`define RPWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/rpwc_pkg.sv
// Shared types and constants for the RC pulse-width capture core.
// No dependencies.
`timescale 1ns / 1ps

package rpwc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int TIMER_BITS   = 16;
  localparam int SLOT_W       = 4;
  localparam int WIDTH_W      = 13;
  localparam int COUNT_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [WIDTH_W-1:0] WIDTH_LOW  = WIDTH_W'(1000);
  localparam logic [WIDTH_W-1:0] WIDTH_HIGH = WIDTH_W'(5000);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [SLOT_W-1:0]  CHAN_LAST  = SLOT_W'(NUM_CHANNELS);

  localparam logic [SLOT_W-1:0]  FS_CHANNEL_RST = SLOT_W'(3);
  localparam logic [WIDTH_W-1:0] FS_MIN_RST     = WIDTH_W'(1500);
  localparam logic [WIDTH_W-1:0] FS_MAX_RST     = WIDTH_W'(4500);
  localparam logic [SLOT_W-1:0]  SPARE_RST      = SLOT_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FS_CHANNEL = 2'd0,
    CFG_FS_MIN     = 2'd1,
    CFG_FS_MAX     = 2'd2,
    CFG_SPARE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  fs_channel;
    logic [WIDTH_W-1:0] fs_min;
    logic [WIDTH_W-1:0] fs_max;
    logic [SLOT_W-1:0]  spare_target;
  } cfg_t;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_W-1:0]     slot;
    logic [TIMER_BITS-1:0] stamp;
  } edge_t;

  typedef struct packed {
    logic               width_valid;
    logic [SLOT_W-1:0]  out_channel;
    logic [WIDTH_W-1:0] pulse_width;
    logic [COUNT_W-1:0] good_pulses;
    logic               radio_lost;
  } result_t;

endpackage

FILE: rtl/rpwc_edge_if.sv
// Valid/ready channel carrying one edge event.
// Depends on rpwc_pkg.
`timescale 1ns / 1ps

interface rpwc_edge_if import rpwc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [SLOT_W-1:0]     slot;
  logic [TIMER_BITS-1:0] stamp;

  modport source (output valid, kind, slot, stamp, input ready);
  modport sink   (input valid, kind, slot, stamp, output ready);
endinterface

FILE: rtl/rpwc_result_if.sv
// Valid/ready channel carrying one measurement result.
// Depends on rpwc_pkg.
`timescale 1ns / 1ps

interface rpwc_result_if import rpwc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               width_valid;
  logic [SLOT_W-1:0]  out_channel;
  logic [WIDTH_W-1:0] pulse_width;
  logic [COUNT_W-1:0] good_pulses;
  logic               radio_lost;

  modport source (output valid, width_valid, out_channel, pulse_width, good_pulses,
                  radio_lost, input ready);
  modport sink   (input valid, width_valid, out_channel, pulse_width, good_pulses,
                  radio_lost, output ready);
endinterface

FILE: rtl/rpwc_cfg_regs.sv
// Configuration register bank: failsafe window, failsafe channel, spare map.
// Depends on rpwc_pkg.
`timescale 1ns / 1ps

module rpwc_cfg_regs import rpwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FS_CHANNEL: cfg_nxt.fs_channel   = cfg_wdata[SLOT_W-1:0];
        CFG_FS_MIN:     cfg_nxt.fs_min       = cfg_wdata[WIDTH_W-1:0];
        CFG_FS_MAX:     cfg_nxt.fs_max       = cfg_wdata[WIDTH_W-1:0];
        CFG_SPARE:      cfg_nxt.spare_target = cfg_wdata[SLOT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fs_channel   <= FS_CHANNEL_RST;
      cfg_r.fs_min       <= FS_MIN_RST;
      cfg_r.fs_max       <= FS_MAX_RST;
      cfg_r.spare_target <= SPARE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rpwc_measure.sv
// Width measurement and failsafe counter: rise stamps per slot, pulse counter.
// Depends on rpwc_pkg.
`timescale 1ns / 1ps

module rpwc_measure import rpwc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  edge_t   item,
  input  logic    fire,
  output result_t res
);

  logic [TIMER_BITS-1:0] rise_r [NUM_CHANNELS+1];
  logic [COUNT_W-1:0]    count_r;
  logic [COUNT_W-1:0]    count_nxt;

  logic                  slot_ok;
  logic [TIMER_BITS-1:0] rise;
  logic [TIMER_BITS-1:0] diff;
  logic [TIMER_BITS-2:0] half;
  logic [SLOT_W-1:0]     target;
  logic                  width_ok;
  logic                  take;
  logic [WIDTH_W-1:0]    width;
  logic                  fs_hit;
  logic                  in_window;

  always_comb begin
    slot_ok   = item.slot <= CHAN_LAST;
    rise      = slot_ok ? rise_r[item.slot] : '0;
    diff      = item.stamp - rise;
    half      = diff[TIMER_BITS-1:1];
    target    = (item.slot == '0) ? cfg.spare_target : item.slot;
    width_ok  = (half >= (TIMER_BITS-1)'(WIDTH_LOW)) && (half <= (TIMER_BITS-1)'(WIDTH_HIGH));
    take      = item.kind && slot_ok && (target != '0) && (target <= CHAN_LAST) && width_ok;
    width     = half[WIDTH_W-1:0];
    fs_hit    = take && (target == cfg.fs_channel);
    in_window = (width > cfg.fs_min) && (width < cfg.fs_max);

    count_nxt = count_r;
    if (fs_hit) begin
      if (!in_window) begin
        count_nxt = '0;
      end else if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end

    res.width_valid = take;
    res.out_channel = take ? target : '0;
    res.pulse_width = take ? width : '0;
    res.good_pulses = count_nxt;
    res.radio_lost  = fs_hit && !in_window;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NUM_CHANNELS; i++) begin
        rise_r[i] <= '0;
      end
      count_r <= '0;
    end else if (fire) begin
      if (!item.kind && slot_ok) begin
        rise_r[item.slot] <= item.stamp;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/rc_pulse_width_capture_core.sv
// RC pulse-width capture core, top level: input register, measure logic, result register.
// An accepted edge passes the input register and then the result register to the output.
// Throughput: one edge per cycle while out_result is ready; the input register refills while a result waits.
// Rise stamps and the pulse counter are read and updated in the single measure stage.
// Reset (rst_n low, synchronous) clears both valid flags, rise stamps, the counter,
// and loads the configuration defaults.
`timescale 1ns / 1ps
`include "rc_pulse_width_capture_core_defines.svh"

module rc_pulse_width_capture_core import rpwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rpwc_edge_if.sink             in_edge,
  rpwc_result_if.source         out_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  edge_t   stg_r;
  logic    stg_v_r;
  logic    stg_v_nxt;
  result_t res;
  result_t res_r;
  logic    out_v_r;
  logic    out_v_nxt;
  logic    adv;
  logic    in_fire;

  rpwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpwc_measure u_measure (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (stg_r),
    .fire  (adv),
    .res   (res)
  );

  assign adv           = stg_v_r && (!out_v_r || out_result.ready);
  assign in_edge.ready = !stg_v_r || adv;
  assign in_fire       = in_edge.valid && in_edge.ready;

  always_comb begin
    stg_v_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : stg_v_r);
    out_v_nxt = adv ? 1'b1 : (out_result.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // hold payloads unless a new transaction moves in
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_r.kind  <= in_edge.kind;
      stg_r.slot  <= in_edge.slot;
      stg_r.stamp <= in_edge.stamp;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_result.valid       = out_v_r;
  assign out_result.width_valid = res_r.width_valid;
  assign out_result.out_channel = res_r.out_channel;
  assign out_result.pulse_width = res_r.pulse_width;
  assign out_result.good_pulses = res_r.good_pulses;
  assign out_result.radio_lost  = res_r.radio_lost;

  `RPWC_ASSERT(a_width_range, out_v_r && res_r.width_valid |-> (res_r.pulse_width >= WIDTH_LOW) && (res_r.pulse_width <= WIDTH_HIGH) && (res_r.out_channel != '0), "accepted width out of range")
  `RPWC_ASSERT(a_idle_fields, out_v_r && !res_r.width_valid |-> (res_r.pulse_width == '0) && (res_r.out_channel == '0) && !res_r.radio_lost, "fields set without a width")
  `RPWC_ASSERT(a_lost_clears, out_v_r && res_r.radio_lost |-> res_r.good_pulses == '0, "counter not cleared on radio loss")
  `RPWC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !stg_v_r && !out_v_r, "pipeline not empty after reset")

endmodule
